FILE: rtl/core/wpf_pkg.sv
// Shared types and codes of the waypoint path follower.
// Used by wpf_ctrl, wpf_dp and the top level; no dependencies.
package wpf_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_RESTART = 3'd1,
        CMD_HOP     = 3'd2,
        CMD_SKIP    = 3'd3,
        CMD_OFF     = 3'd4
    } cmd_code_t;

    localparam logic [1:0] CFG_ROUTE_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_REACH_RADIUS   = 2'd1;
    localparam logic [1:0] CFG_REACH_HEIGHT   = 2'd2;
    localparam logic [1:0] CFG_OFF_PATH_LIMIT = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 16;

    // multiplier operand pairs
    typedef enum logic [3:0] {
        T_WXWX, T_WYWY, T_VXVX, T_VYVY, T_EXEX, T_EYEY,
        T_WXEX, T_WYEY, T_WXEY, T_WYEX, T_CRCR, T_T2L
    } term_t;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_mode_t;

    typedef enum logic [1:0] {
        RD_CUR, RD_PREV, RD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic      in_load;
        logic      mem_wr;
        logic      restart;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      load_a;
        logic      load_b;
        logic      mul_start;
        term_t     term;
        acc_mode_t mode;
        logic      save_l;
        logic      save_cr;
        logic      save_q;
        logic      cur_inc;
        logic      set_done;
        logic      set_hit;
        logic      set_flag;
        logic      tick_clr;
        logic      tick_inc;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      cur_lt_len;
        logic      cur_gt0;
        logic      nxt_lt_len;
        logic      mul_done;
        logic      s_zero;
        logic      s_le0;
        logic      s_ge_l;
        logic      s_gt_r2;
        logic      s_gt_t2;
        logic      q_gt_s;
        logic      vert_in;
        logic      a_jump;
        logic      out_free;
    } dp_sts_t;

endpackage

FILE: rtl/core/waypoint_path_follower_core.sv
// Each multiply uses the shared shift-add multiplier, P = max(2*COORD_BITS+2, 32) bits wide.
// Next hop: two multiplies per waypoint walked; skip stranded likewise for one point.
// Off path check: up to 16 multiplies plus reads.
// One transaction in flight; the shared shift-add multiplier sets the rate.
// A finished result waits in the output register while the next transaction is accepted.
// Reset: asynchronous, active low; cursor and counter clear, config to defaults, memory kept.
module waypoint_path_follower_core
    import wpf_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 20
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // point_index, pos_x, pos_y, pos_z, jump_landing
    input  logic [((3*COORD_BITS+INDEX_W+1+7)/8)*8-1:0]  s_tdata,
    // cmd
    input  logic [2:0]                                   s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // point_x, point_y, point_z, is_jump, route_done, flag, off_count
    output logic [((3*COORD_BITS+COUNT_W+3+7)/8)*8-1:0]  m_tdata,
    input  logic                                         cfg_wr_en,
    input  logic [1:0]                                   cfg_index,
    input  logic [CFG_DATA_W-1:0]                        cfg_data
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    wpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    wpf_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("transaction accepted while another is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote an untaken transaction");

    a_mul_single: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.mul_start |=> !dp_cmd.mul_start)
        else $error("multiplier restarted while busy");
`endif

endmodule

FILE: rtl/core/wpf_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// No package dependencies; instantiated by wpf_dp.
module wpf_mul #(
    parameter int P = 42
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [P-1:0]     a,
    input  logic [P-1:0]     b,
    output logic [2*P-1:0]   prod,
    output logic             done
);

    localparam int NW = $clog2(P);

    logic [P-1:0]  a_reg;
    logic [P-1:0]  hi_reg;
    logic [P-1:0]  lo_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [P:0]    sum;

    assign sum  = (P+1)'(hi_reg) + (lo_reg[0] ? (P+1)'(a_reg) : '0);
    assign prod = {hi_reg, lo_reg};
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + NW'(1);
                if (cnt_reg == NW'(P-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[P:1];
            lo_reg <= {sum[0], lo_reg[P-1:1]};
        end
    end

endmodule

FILE: rtl/core/wpf_dp.sv
// Datapath: route memory, cursor, config registers, accumulator and result.
// Depends on wpf_pkg and wpf_mul.
module wpf_dp
    import wpf_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 20
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  dp_cmd_t                                      cmd,
    output dp_sts_t                                      sts,
    input  logic [((3*COORD_BITS+INDEX_W+1+7)/8)*8-1:0]  s_tdata,
    input  logic [2:0]                                   s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [((3*COORD_BITS+COUNT_W+3+7)/8)*8-1:0]  m_tdata,
    input  logic                                         cfg_wr_en,
    input  logic [1:0]                                   cfg_index,
    input  logic [CFG_DATA_W-1:0]                        cfg_data
);

    localparam int C     = COORD_BITS;
    localparam int D     = C + 1;
    localparam int P     = (2*D > 32) ? 2*D : 32;
    localparam int SW    = 2*P + 1;
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = (AW + 1 > 11) ? AW + 1 : 11;
    localparam int HW    = D + 16;
    localparam int MW    = 3*C + 1;
    localparam int OUT_W = ((3*C + COUNT_W + 3 + 7) / 8) * 8;

    logic [MW-1:0]       mem [MAX_POINTS];
    logic [MW-1:0]       rd_q;

    cmd_code_t           cmd_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic signed [C-1:0] px_reg, py_reg, pz_reg;
    logic                jin_reg;
    logic signed [C-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg;
    logic                aj_reg;

    logic [CW-1:0]       cursor_reg;
    logic [COUNT_W-1:0]  ticks_reg;
    logic [10:0]         route_length_reg;
    logic [11:0]         reach_radius_reg;
    logic [15:0]         reach_height_reg;
    logic [15:0]         off_path_limit_reg;

    logic signed [SW-1:0] s_reg;
    logic [P-1:0]         l_reg;
    logic signed [P:0]    cr_reg;
    logic [2*P-1:0]       q_reg;
    logic                 neg_reg;
    acc_mode_t            mode_reg;

    logic res_hit_reg, res_jmp_reg, res_done_reg, res_flag_reg;
    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic [CW-1:0]       len_eff;
    logic [AW-1:0]       cur_addr, rd_addr;
    logic signed [D-1:0] wx, wy, vx, vy, ex, ey, dz;
    logic [D-1:0]        dz_mag;
    logic [23:0]         r2;
    logic [31:0]         t2;
    logic signed [P:0]   opa, opb;
    logic [P-1:0]        mag_a, mag_b;
    logic [2*P-1:0]      prod;
    logic                mul_done;
    logic [SW-1:0]       p_ext, p_term;
    logic                p_neg;
    logic                idx_ok;

    assign len_eff  = (CW'(route_length_reg) > CW'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                               : CW'(route_length_reg);
    assign cur_addr = cursor_reg[AW-1:0];
    assign idx_ok   = (32'(idx_reg) < 32'(MAX_POINTS));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_addr = cur_addr - AW'(1);
            RD_NEXT: rd_addr = cur_addr + AW'(1);
            default: rd_addr = cur_addr;
        endcase
    end

    assign wx = D'(px_reg) - D'(ax_reg);
    assign wy = D'(py_reg) - D'(ay_reg);
    assign vx = D'(px_reg) - D'(bx_reg);
    assign vy = D'(py_reg) - D'(by_reg);
    assign ex = D'(bx_reg) - D'(ax_reg);
    assign ey = D'(by_reg) - D'(ay_reg);
    assign dz = D'(pz_reg) - D'(az_reg);
    assign dz_mag = dz[D-1] ? D'(-dz) : D'(dz);

    assign r2 = 24'(reach_radius_reg) * 24'(reach_radius_reg);
    assign t2 = 32'(off_path_limit_reg) * 32'(off_path_limit_reg);

    always_comb
    begin
        case (cmd.term)
            T_WXWX:  begin opa = (P+1)'(wx); opb = (P+1)'(wx); end
            T_WYWY:  begin opa = (P+1)'(wy); opb = (P+1)'(wy); end
            T_VXVX:  begin opa = (P+1)'(vx); opb = (P+1)'(vx); end
            T_VYVY:  begin opa = (P+1)'(vy); opb = (P+1)'(vy); end
            T_EXEX:  begin opa = (P+1)'(ex); opb = (P+1)'(ex); end
            T_EYEY:  begin opa = (P+1)'(ey); opb = (P+1)'(ey); end
            T_WXEX:  begin opa = (P+1)'(wx); opb = (P+1)'(ex); end
            T_WYEY:  begin opa = (P+1)'(wy); opb = (P+1)'(ey); end
            T_WXEY:  begin opa = (P+1)'(wx); opb = (P+1)'(ey); end
            T_WYEX:  begin opa = (P+1)'(wy); opb = (P+1)'(ex); end
            T_CRCR:  begin opa = cr_reg;     opb = cr_reg;     end
            T_T2L:   begin opa = $signed((P+1)'(t2)); opb = $signed((P+1)'(l_reg)); end
            default: begin opa = '0;         opb = '0;         end
        endcase
    end

    assign mag_a = opa[P] ? P'(-opa) : opa[P-1:0];
    assign mag_b = opb[P] ? P'(-opb) : opb[P-1:0];

    wpf_mul #(.P(P)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mag_a),
        .b     (mag_b),
        .prod  (prod),
        .done  (mul_done)
    );

    assign p_ext  = SW'(prod);
    assign p_neg  = neg_reg ^ (mode_reg == ACC_SUB);
    assign p_term = p_neg ? (SW'(0) - p_ext) : p_ext;

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.cur_lt_len = cursor_reg < len_eff;
        sts.cur_gt0    = cursor_reg != '0;
        sts.nxt_lt_len = ((CW+1)'(cursor_reg) + (CW+1)'(1)) < (CW+1)'(len_eff);
        sts.mul_done   = mul_done;
        sts.s_zero     = s_reg == '0;
        sts.s_le0      = s_reg[SW-1] || (s_reg == '0);
        sts.s_ge_l     = s_reg >= $signed(SW'(l_reg));
        sts.s_gt_r2    = s_reg > $signed(SW'(r2));
        sts.s_gt_t2    = s_reg > $signed(SW'(t2));
        sts.q_gt_s     = q_reg > s_reg[2*P-1:0];
        sts.vert_in    = HW'(dz_mag) <= HW'(reach_height_reg);
        sts.a_jump     = aj_reg;
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && idx_ok)
        begin
            mem[AW'(idx_reg)] <= {jin_reg, pz_reg, py_reg, px_reg};
        end
        if (cmd.rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            idx_reg <= s_tdata[INDEX_W-1:0];
            px_reg  <= s_tdata[INDEX_W +: C];
            py_reg  <= s_tdata[INDEX_W+C +: C];
            pz_reg  <= s_tdata[INDEX_W+2*C +: C];
            jin_reg <= s_tdata[INDEX_W+3*C];
        end
        if (cmd.load_a)
        begin
            {aj_reg, az_reg, ay_reg, ax_reg} <= rd_q;
        end
        if (cmd.load_b)
        begin
            bx_reg <= rd_q[C-1:0];
            by_reg <= rd_q[2*C-1:C];
        end
        if (cmd.mul_start)
        begin
            neg_reg  <= opa[P] ^ opb[P];
            mode_reg <= cmd.mode;
        end
        if (mul_done)
        begin
            s_reg <= (mode_reg == ACC_LOAD) ? p_term : s_reg + p_term;
        end
        if (cmd.save_l)
        begin
            l_reg <= s_reg[P-1:0];
        end
        if (cmd.save_cr)
        begin
            cr_reg <= s_reg[P:0];
        end
        if (cmd.save_q)
        begin
            q_reg <= s_reg[2*P-1:0];
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= OUT_W'({ticks_reg, res_flag_reg, res_done_reg, res_jmp_reg,
                                   res_hit_reg ? {az_reg, ay_reg, ax_reg} : {(3*C){1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg            <= CMD_WRITE;
            cursor_reg         <= '0;
            ticks_reg          <= '0;
            route_length_reg   <= 11'd0;
            reach_radius_reg   <= 12'd32;
            reach_height_reg   <= 16'd64;
            off_path_limit_reg <= 16'd80;
            res_hit_reg        <= 1'b0;
            res_jmp_reg        <= 1'b0;
            res_done_reg       <= 1'b0;
            res_flag_reg       <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ROUTE_LENGTH:   route_length_reg   <= cfg_data[10:0];
                    CFG_REACH_RADIUS:   reach_radius_reg   <= cfg_data[11:0];
                    CFG_REACH_HEIGHT:   reach_height_reg   <= cfg_data;
                    CFG_OFF_PATH_LIMIT: off_path_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.in_load)
            begin
                cmd_reg      <= cmd_code_t'(s_tuser);
                res_hit_reg  <= 1'b0;
                res_jmp_reg  <= 1'b0;
                res_done_reg <= 1'b0;
                res_flag_reg <= 1'b0;
            end
            if (cmd.set_done)
            begin
                res_done_reg <= 1'b1;
            end
            if (cmd.set_hit)
            begin
                res_hit_reg  <= 1'b1;
                res_jmp_reg  <= aj_reg;
                res_done_reg <= 1'b0;
            end
            if (cmd.set_flag)
            begin
                res_flag_reg <= 1'b1;
            end
            if (cmd.restart)
            begin
                cursor_reg <= '0;
            end
            else if (cmd.cur_inc)
            begin
                cursor_reg <= cursor_reg + CW'(1);
            end
            if (cmd.restart || cmd.tick_clr)
            begin
                ticks_reg <= '0;
            end
            else if (cmd.tick_inc && (ticks_reg != {COUNT_W{1'b1}}))
            begin
                ticks_reg <= ticks_reg + COUNT_W'(1);
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/wpf_ctrl.sv
// Controller state machine: sequences reads, multiplies and result updates.
// Depends on wpf_pkg; drives wpf_dp through dp_cmd_t.
module wpf_ctrl
    import wpf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISP, ST_HOP_CHK, ST_RD_CUR, ST_LD_CUR, ST_RC1, ST_RC2,
        ST_RCH_EVAL, ST_MWAIT, ST_OFF_START, ST_P1_RDA, ST_P1_RDB, ST_SEG_LDB,
        ST_OFF_S2, ST_P2_RDA, ST_P2_RDB, ST_OFF_END, ST_P3_RD, ST_P3_LD,
        ST_SG_L1, ST_SG_L2, ST_SG_L3, ST_SG_D1, ST_SG_D2, ST_SG_D3,
        ST_SG_W1, ST_SG_W2, ST_SG_V1, ST_SG_V2, ST_SG_PT_EV,
        ST_SG_C1, ST_SG_C2, ST_SG_C3, ST_SG_C4, ST_SG_C5, ST_SG_C7,
        ST_SG_END, ST_OFF_FIN, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_SEG1, PH_SEG2, PH_PT
    } phase_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    phase_t phase_reg, phase_next;
    logic   any_reg, any_next, off_reg, off_next, far_reg, far_next;
    logic   horiz;

    assign horiz    = !sts.s_gt_r2;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        phase_next = phase_reg;
        any_next   = any_reg;
        off_next   = off_reg;
        far_next   = far_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (sts.cmd)
                    CMD_WRITE:
                    begin
                        cmd.mem_wr = 1'b1;
                        state_next = ST_FINISH;
                    end
                    CMD_RESTART:
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    CMD_HOP:
                    begin
                        cmd.set_done = 1'b1;
                        state_next   = ST_HOP_CHK;
                    end
                    CMD_SKIP:   state_next = sts.cur_lt_len ? ST_RD_CUR : ST_FINISH;
                    CMD_OFF:    state_next = ST_OFF_START;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_HOP_CHK: state_next = sts.cur_lt_len ? ST_RD_CUR : ST_FINISH;
            ST_RD_CUR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = ST_LD_CUR;
            end
            ST_LD_CUR:
            begin
                cmd.load_a = 1'b1;
                state_next = ST_RC1;
            end
            ST_RC1:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WXWX;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_RC2;
                state_next    = ST_MWAIT;
            end
            ST_RC2:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WYWY;
                cmd.mode      = ACC_ADD;
                ret_next      = ST_RCH_EVAL;
                state_next    = ST_MWAIT;
            end
            ST_RCH_EVAL:
            begin
                if (sts.cmd == CMD_HOP)
                begin
                    if (horiz && sts.vert_in)
                    begin
                        cmd.cur_inc = 1'b1;
                        state_next  = ST_HOP_CHK;
                    end
                    else
                    begin
                        cmd.set_hit = 1'b1;
                        state_next  = ST_FINISH;
                    end
                end
                else
                begin
                    if (horiz && !sts.vert_in && !sts.a_jump)
                    begin
                        cmd.cur_inc = 1'b1;
                        if (sts.nxt_lt_len)
                        begin
                            cmd.set_hit  = 1'b1;
                            cmd.set_flag = 1'b1;
                            cmd.tick_clr = 1'b1;
                        end
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_OFF_START:
            begin
                if (!sts.cur_lt_len)
                begin
                    cmd.tick_clr = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    any_next = 1'b0;
                    off_next = 1'b1;
                    if (sts.cur_gt0)
                    begin
                        phase_next = PH_SEG1;
                        state_next = ST_P1_RDA;
                    end
                    else
                    begin
                        state_next = ST_OFF_S2;
                    end
                end
            end
            ST_P1_RDA:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PREV;
                state_next = ST_P1_RDB;
            end
            ST_P1_RDB:
            begin
                cmd.load_a = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = ST_SEG_LDB;
            end
            ST_SEG_LDB:
            begin
                cmd.load_b = 1'b1;
                state_next = ST_SG_L1;
            end
            ST_OFF_S2:
            begin
                if (sts.nxt_lt_len)
                begin
                    phase_next = PH_SEG2;
                    state_next = ST_P2_RDA;
                end
                else
                begin
                    state_next = ST_OFF_END;
                end
            end
            ST_P2_RDA:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = ST_P2_RDB;
            end
            ST_P2_RDB:
            begin
                cmd.load_a = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = ST_SEG_LDB;
            end
            ST_OFF_END:
            begin
                if (any_reg)
                begin
                    state_next = ST_OFF_FIN;
                end
                else
                begin
                    phase_next = PH_PT;
                    state_next = ST_P3_RD;
                end
            end
            ST_P3_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = ST_P3_LD;
            end
            ST_P3_LD:
            begin
                cmd.load_a = 1'b1;
                state_next = ST_SG_W1;
            end
            ST_SG_L1:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_EXEX;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_SG_L2;
                state_next    = ST_MWAIT;
            end
            ST_SG_L2:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_EYEY;
                cmd.mode      = ACC_ADD;
                ret_next      = ST_SG_L3;
                state_next    = ST_MWAIT;
            end
            ST_SG_L3:
            begin
                cmd.save_l = 1'b1;
                state_next = sts.s_zero ? ST_SG_W1 : ST_SG_D1;
            end
            ST_SG_D1:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WXEX;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_SG_D2;
                state_next    = ST_MWAIT;
            end
            ST_SG_D2:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WYEY;
                cmd.mode      = ACC_ADD;
                ret_next      = ST_SG_D3;
                state_next    = ST_MWAIT;
            end
            ST_SG_D3:
            begin
                if (sts.s_le0)
                begin
                    state_next = ST_SG_W1;
                end
                else if (sts.s_ge_l)
                begin
                    state_next = ST_SG_V1;
                end
                else
                begin
                    state_next = ST_SG_C1;
                end
            end
            ST_SG_W1:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WXWX;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_SG_W2;
                state_next    = ST_MWAIT;
            end
            ST_SG_W2:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WYWY;
                cmd.mode      = ACC_ADD;
                ret_next      = ST_SG_PT_EV;
                state_next    = ST_MWAIT;
            end
            ST_SG_V1:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_VXVX;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_SG_V2;
                state_next    = ST_MWAIT;
            end
            ST_SG_V2:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_VYVY;
                cmd.mode      = ACC_ADD;
                ret_next      = ST_SG_PT_EV;
                state_next    = ST_MWAIT;
            end
            ST_SG_PT_EV:
            begin
                far_next   = sts.s_gt_t2;
                state_next = ST_SG_END;
            end
            ST_SG_C1:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WXEY;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_SG_C2;
                state_next    = ST_MWAIT;
            end
            ST_SG_C2:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_WYEX;
                cmd.mode      = ACC_SUB;
                ret_next      = ST_SG_C3;
                state_next    = ST_MWAIT;
            end
            ST_SG_C3:
            begin
                cmd.save_cr = 1'b1;
                state_next  = ST_SG_C4;
            end
            ST_SG_C4:
            begin
                cmd.mul_start = 1'b1;
                cmd.term      = T_CRCR;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_SG_C5;
                state_next    = ST_MWAIT;
            end
            ST_SG_C5:
            begin
                cmd.save_q    = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.term      = T_T2L;
                cmd.mode      = ACC_LOAD;
                ret_next      = ST_SG_C7;
                state_next    = ST_MWAIT;
            end
            ST_SG_C7:
            begin
                far_next   = sts.q_gt_s;
                state_next = ST_SG_END;
            end
            ST_SG_END:
            begin
                case (phase_reg)
                    PH_PT:
                    begin
                        off_next   = far_reg;
                        state_next = ST_OFF_FIN;
                    end
                    PH_SEG1:
                    begin
                        any_next   = 1'b1;
                        off_next   = off_reg && far_reg;
                        state_next = ST_OFF_S2;
                    end
                    default:
                    begin
                        any_next   = 1'b1;
                        off_next   = off_reg && far_reg;
                        state_next = ST_OFF_END;
                    end
                endcase
            end
            ST_OFF_FIN:
            begin
                if (off_reg)
                begin
                    cmd.tick_inc = 1'b1;
                    cmd.set_flag = 1'b1;
                end
                else
                begin
                    cmd.tick_clr = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            phase_reg <= PH_SEG1;
            any_reg   <= 1'b0;
            off_reg   <= 1'b0;
            far_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            phase_reg <= phase_next;
            any_reg   <= any_next;
            off_reg   <= off_next;
            far_reg   <= far_next;
        end
    end

endmodule

FILE: tb/waypoint_path_follower_core_tb.sv
// Self-checking testbench for waypoint_path_follower_core: random and directed route commands
// are checked against an in-bench route follower model. Depends on wpf_pkg and the core RTL.
module waypoint_path_follower_core_tb;
    import wpf_pkg::*;

    typedef logic signed [127:0] big_t;

    typedef struct {
        logic [2:0]         cmd;
        logic [9:0]         idx;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic               jmp;
    } route_cmd_t;

    typedef struct {
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] z;
        logic        jmp;
        logic        done;
        logic        flag;
        logic [15:0] cnt;
    } hop_result_t;

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic               jmp;
    } waypoint_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    waypoint_path_follower_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    waypoint_t   route_mem [1024];
    int          cursor_pos;
    int          off_ticks;
    int          route_len;
    int          radius;
    int          height;
    int          off_limit;

    route_cmd_t  cmd_queue[$];
    hop_result_t results_due[$];
    int          errors;
    int          sent_cnt;
    int          taken_cnt;
    int          checked_cnt;
    bit          no_idle;

    // generator-side copy of the route
    int          gx [1024];
    int          gy [1024];
    int          gz [1024];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 8000000);
        $display("** waypoint_path_follower_core: FAILED **");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch #%0d at %0t: %s", errors + 1, $realtime, what);
        errors++;
    endtask

    function automatic big_t sq_dist(big_t dx, big_t dy);
        return dx * dx + dy * dy;
    endfunction

    // squared distance from (px,py) to segment a-b exceeds t2
    function automatic bit seg_far(big_t px, big_t py, waypoint_t a, waypoint_t b, big_t t2);
        big_t ax, ay, bx, by, ex, ey, wx, wy, len2, dot, cr;
        ax = a.x; ay = a.y; bx = b.x; by = b.y;
        ex = bx - ax; ey = by - ay;
        wx = px - ax; wy = py - ay;
        len2 = sq_dist(ex, ey);
        if (len2 == 0)
            return sq_dist(wx, wy) > t2;
        dot = wx * ex + wy * ey;
        if (dot <= 0)
            return sq_dist(wx, wy) > t2;
        if (dot >= len2)
            return sq_dist(px - bx, py - by) > t2;
        cr = wx * ey - wy * ex;
        return cr * cr > t2 * len2;
    endfunction

    function automatic bit horiz_reached(big_t px, big_t py, waypoint_t p);
        big_t r, wx, wy;
        r = radius;
        wx = p.x;
        wy = p.y;
        return sq_dist(px - wx, py - wy) <= r * r;
    endfunction

    function automatic bit vert_reached(big_t pz, waypoint_t p);
        big_t wz, d, h;
        wz = p.z;
        h = height;
        d = pz - wz;
        if (d < 0)
            d = -d;
        return d <= h;
    endfunction

    task automatic follow_route(input route_cmd_t c, output hop_result_t r);
        big_t      px, py, pz, t2, cx, cy;
        int        len;
        bit        any, off;
        waypoint_t p;
        px = c.x; py = c.y; pz = c.z;
        len = (route_len > 1024) ? 1024 : route_len;
        r = '{default: '0};
        case (c.cmd)
            CMD_WRITE:
                route_mem[c.idx] = '{c.x, c.y, c.z, c.jmp};
            CMD_RESTART:
            begin
                cursor_pos = 0;
                off_ticks = 0;
            end
            CMD_HOP:
            begin
                r.done = 1'b1;
                while (cursor_pos < len)
                begin
                    p = route_mem[cursor_pos];
                    if (!(horiz_reached(px, py, p) && vert_reached(pz, p)))
                    begin
                        r.x = p.x; r.y = p.y; r.z = p.z;
                        r.jmp = p.jmp;
                        r.done = 1'b0;
                        break;
                    end
                    cursor_pos++;
                end
            end
            CMD_SKIP:
            begin
                if (cursor_pos < len)
                begin
                    p = route_mem[cursor_pos];
                    if (horiz_reached(px, py, p) && !vert_reached(pz, p) && !p.jmp)
                    begin
                        cursor_pos++;
                        if (cursor_pos < len)
                        begin
                            r.x = p.x; r.y = p.y; r.z = p.z;
                            r.flag = 1'b1;
                            off_ticks = 0;
                        end
                    end
                end
            end
            CMD_OFF:
            begin
                if (cursor_pos >= len)
                    off_ticks = 0;
                else
                begin
                    t2 = off_limit;
                    t2 = t2 * t2;
                    any = 1'b0;
                    off = 1'b1;
                    if (cursor_pos > 0)
                    begin
                        any = 1'b1;
                        if (!seg_far(px, py, route_mem[cursor_pos - 1],
                                     route_mem[cursor_pos], t2))
                            off = 1'b0;
                    end
                    if (cursor_pos + 1 < len)
                    begin
                        any = 1'b1;
                        if (!seg_far(px, py, route_mem[cursor_pos],
                                     route_mem[cursor_pos + 1], t2))
                            off = 1'b0;
                    end
                    if (!any)
                    begin
                        cx = route_mem[cursor_pos].x;
                        cy = route_mem[cursor_pos].y;
                        off = sq_dist(px - cx, py - cy) > t2;
                    end
                    if (off)
                    begin
                        if (off_ticks < 65535)
                            off_ticks++;
                    end
                    else
                        off_ticks = 0;
                    r.flag = off;
                end
            end
            default: ;
        endcase
        r.cnt = off_ticks[15:0];
    endtask

    // input side: accept and predict
    always @(posedge clk)
    begin
        hop_result_t r;
        route_cmd_t  c;
        if (rst_n && s_tvalid && s_tready)
        begin
            c.idx = s_tdata[9:0];
            c.x   = s_tdata[29:10];
            c.y   = s_tdata[49:30];
            c.z   = s_tdata[69:50];
            c.jmp = s_tdata[70];
            c.cmd = s_tuser;
            follow_route(c, r);
            results_due.insert(results_due.size(), r);
            taken_cnt++;
        end
    end

    // output side: compare each transaction
    always @(posedge clk)
    begin
        hop_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
                report("result with nothing expected");
            else
            begin
                e = results_due.pop_front();
                if (m_tdata[19:0] !== e.x)
                    report($sformatf("point_x %h exp %h", m_tdata[19:0], e.x));
                if (m_tdata[39:20] !== e.y)
                    report($sformatf("point_y %h exp %h", m_tdata[39:20], e.y));
                if (m_tdata[59:40] !== e.z)
                    report($sformatf("point_z %h exp %h", m_tdata[59:40], e.z));
                if (m_tdata[60] !== e.jmp)
                    report($sformatf("is_jump %b exp %b", m_tdata[60], e.jmp));
                if (m_tdata[61] !== e.done)
                    report($sformatf("route_done %b exp %b", m_tdata[61], e.done));
                if (m_tdata[62] !== e.flag)
                    report($sformatf("flag %b exp %b", m_tdata[62], e.flag));
                if (m_tdata[78:63] !== e.cnt)
                    report($sformatf("off_count %0d exp %0d", m_tdata[78:63], e.cnt));
                checked_cnt++;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        route_cmd_t c;
        if (rst_n)
        begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 36);
            if (!(s_tvalid && taken_cnt != sent_cnt))
            begin
                if (cmd_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36))
                begin
                    c = cmd_queue.pop_front();
                    s_tdata  <= {1'b0, c.jmp, c.z, c.y, c.x, c.idx};
                    s_tuser  <= c.cmd;
                    s_tvalid <= 1'b1;
                    sent_cnt++;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    function automatic int spread(int a);
        return $urandom_range(0, 2 * a) - a;
    endfunction

    task automatic push_cmd(input logic [2:0] cmd, input int idx, input int x, input int y,
                            input int z, input logic jmp);
        route_cmd_t c;
        c = '{cmd, idx[9:0], x[19:0], y[19:0], z[19:0], jmp};
        if (cmd == CMD_WRITE)
        begin
            gx[c.idx] = c.x;
            gy[c.idx] = c.y;
            gz[c.idx] = c.z;
        end
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        case (idx)
            CFG_ROUTE_LENGTH: route_len = val & 'h7FF;
            CFG_REACH_RADIUS: radius    = val & 'hFFF;
            CFG_REACH_HEIGHT: height    = val & 'hFFFF;
            default:          off_limit = val & 'hFFFF;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_queue.size() != 0 || taken_cnt != sent_cnt || s_tvalid
               || results_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    int ph_len    [8] = '{8, 1, 2, 16, 1024, 2047, 5, 12};
    int ph_radius [8] = '{64, 0, 4095, 200, 100, 48, 300, 80};
    int ph_height [8] = '{100, 0, 65535, 300, 40, 64, 200, 20};
    int ph_limit  [8] = '{120, 0, 65535, 500, 90, 60, 400, 30};

    initial
    begin
        int len, wlen, k, bx, by, bz, sel, step, issued, x, y, z;
        logic [2:0] op;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        sent_cnt = 0;
        taken_cnt = 0;
        checked_cnt = 0;
        no_idle = 1'b0;
        cursor_pos = 0;
        off_ticks = 0;
        route_len = 0;
        radius = 32;
        height = 64;
        off_limit = 80;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every slot so no read ever hits an unwritten entry
        for (int i = 0; i < 1024; i++)
            push_cmd(CMD_WRITE, i, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        // directed: empty route, extremes, unknown commands
        push_cmd(CMD_WRITE, 1023, -524288, 524287, -524288, 1'b1);
        push_cmd(CMD_WRITE, 0, 524287, -524288, 524287, 1'b0);
        push_cmd(CMD_HOP, 0, 0, 0, 0, 1'b0);
        push_cmd(CMD_SKIP, 0, 0, 0, 0, 1'b0);
        push_cmd(CMD_OFF, 0, -524288, -524288, -524288, 1'b0);
        push_cmd(CMD_RESTART, 0, 524287, 524287, 524287, 1'b1);
        for (int c = 5; c < 8; c++)
            push_cmd(3'(c), 1023, 524287, -1, 1, 1'b1);
        drain();
        set_reg(CFG_ROUTE_LENGTH, 1024);
        push_cmd(CMD_HOP, 0, gx[0], gy[0], gz[0], 1'b0);
        push_cmd(CMD_OFF, 0, -524288, 524287, 0, 1'b0);
        push_cmd(CMD_OFF, 0, -524288, 524287, 0, 1'b0);
        push_cmd(CMD_SKIP, 0, gx[1], gy[1], gz[1] + 5000, 1'b0);
        push_cmd(CMD_RESTART, 0, 0, 0, 0, 1'b0);
        drain();

        issued = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph == 3);
            set_reg(CFG_ROUTE_LENGTH, ph_len[ph]);
            set_reg(CFG_REACH_RADIUS, ph_radius[ph]);
            set_reg(CFG_REACH_HEIGHT, ph_height[ph]);
            set_reg(CFG_OFF_PATH_LIMIT, ph_limit[ph]);
            len = (route_len > 1024) ? 1024 : route_len;
            wlen = (len > 32) ? 32 : len;
            step = 2 * radius + 16;
            bx = spread(200000);
            by = spread(200000);
            bz = spread(100000);
            for (int i = 0; i < wlen; i++)
            begin
                push_cmd(CMD_WRITE, i, bx, by, bz, $urandom_range(0, 5) == 0);
                bx += spread(step);
                by += spread(step);
                bz += spread(height + 8);
            end
            push_cmd(CMD_RESTART, 0, 0, 0, 0, 1'b0);
            for (int n = 0; n < 64; n++)
            begin
                k = $urandom_range(0, wlen - 1);
                x = gx[k];
                y = gy[k];
                z = gz[k];
                sel = $urandom_range(0, 99);
                if (sel < 12)
                    push_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
                             1'($urandom_range(0, 1)));
                else if (sel < 15)
                    push_cmd(CMD_WRITE, $urandom, $urandom, $urandom, $urandom,
                             1'($urandom_range(0, 1)));
                else if (sel < 22)
                    push_cmd(CMD_WRITE, k, x + spread(step), y + spread(step),
                             z + spread(height), $urandom_range(0, 5) == 0);
                else if (sel < 26)
                    push_cmd(CMD_RESTART, 0, x, y, z, 1'b0);
                else if (sel < 58)
                    push_cmd(CMD_HOP, 0, x + spread(radius / 2), y + spread(radius / 2),
                             z + spread(height + 2), 1'b0);
                else if (sel < 76)
                    push_cmd(CMD_SKIP, 0, x + spread(radius / 2), y + spread(radius / 2),
                             z + (($urandom_range(0, 1) == 1) ? 1 : -1)
                               * (height + $urandom_range(0, 400)), 1'b0);
                else
                begin
                    op = CMD_OFF;
                    push_cmd(op, 0, x + spread(2 * off_limit + 4),
                             y + spread(2 * off_limit + 4), z, 1'b0);
                end
                issued++;
            end
            drain();
        end

        no_idle = 1'b0;
        drain();
        $display("covered %0d checked transactions over 8 route settings plus directed cases",
                 checked_cnt);
        $display("random and directed commands issued: %0d, errors: %0d", issued, errors);
        if (errors == 0)
            $display("** waypoint_path_follower_core: PASSED **");
        else
            $display("** waypoint_path_follower_core: FAILED **");
        $finish;
    end

endmodule
